@@ rtl/lbsw_pkg.sv @@
// Package with types, band edge table and register codes of the band waterfall.
package lbsw_pkg;

	localparam int FftBins = 128;
	localparam int Bands = 16;
	localparam int HistDepth = 32;
	localparam int BinW = 8;
	localparam int BandW = 4;
	localparam int ColW = 5;
	localparam int SumW = 23;
	localparam int CntW = 7;
	localparam int HistAw = BandW + ColW;
	localparam int HistEntries = Bands * HistDepth;
	localparam int PaddrW = 3;

	localparam logic [PaddrW-1:0] RegCeiling = 3'd0;
	localparam logic [PaddrW-1:0] RegFloor = 3'd4;

	typedef struct packed {
		logic        func;
		logic [15:0] bin_magnitude;
		logic        frame_end;
		logic [4:0]  read_age;
		logic [3:0]  read_band;
	} in_word_t;

	typedef struct packed {
		logic [7:0] level_byte;
		logic [3:0] band_row;
		logic       is_read_reply;
		logic       column_last;
	} out_word_t;

	// Band edges for 128 bins and 16 bands: floor(128^(k/16)), clipped to [1,127].
	function automatic logic [CntW-1:0] band_lo(input logic [BandW-1:0] b);
		case (b)
			4'd0: band_lo = 7'd1;   4'd1: band_lo = 7'd1;
			4'd2: band_lo = 7'd1;   4'd3: band_lo = 7'd2;
			4'd4: band_lo = 7'd3;   4'd5: band_lo = 7'd4;
			4'd6: band_lo = 7'd6;   4'd7: band_lo = 7'd8;
			4'd8: band_lo = 7'd11;  4'd9: band_lo = 7'd15;
			4'd10: band_lo = 7'd20; 4'd11: band_lo = 7'd28;
			4'd12: band_lo = 7'd38; 4'd13: band_lo = 7'd51;
			4'd14: band_lo = 7'd69; 4'd15: band_lo = 7'd94;
			default: band_lo = 7'd1;
		endcase
	endfunction

	function automatic logic [CntW-1:0] band_hi(input logic [BandW-1:0] b);
		if (b == 4'd15) begin
			band_hi = 7'd127;
		end else begin
			band_hi = band_lo(b + 4'd1);
		end
	endfunction

	// Reciprocal of a band width, scaled by 2^26 and rounded up; exact for every sum
	// that a band of that width can reach.
	function automatic logic [26:0] band_recip(input logic [CntW-1:0] c);
		case (c)
			7'd1: band_recip = 27'd67108864;
			7'd2: band_recip = 27'd33554432;
			7'd3: band_recip = 27'd22369622;
			7'd4: band_recip = 27'd16777216;
			7'd5: band_recip = 27'd13421773;
			7'd8: band_recip = 27'd8388608;
			7'd10: band_recip = 27'd6710887;
			7'd13: band_recip = 27'd5162221;
			7'd18: band_recip = 27'd3728271;
			7'd25: band_recip = 27'd2684355;
			7'd33: band_recip = 27'd2033602;
			default: band_recip = 27'd0;
		endcase
	endfunction

endpackage

@@ rtl/log_band_spectrum_waterfall.sv @@
// Top level of the logarithmic band spectrum waterfall.
// A bin word takes a band sum read, then an add and write back on the sum memory's write port.
// A frame end word is accumulated like a bin word, then per band: sum read, average by
// reciprocal multiply, floor clamp (above the ceiling gives zero), a 24-step restoring
// division for 255*avg/peak, then the history write and column word, once output is free.
// A read word is answered through ST_RREAD and ST_OUT; input waits until it is taken.
// Reset clears control state at once, then sweeps 512 history cells and 16 band sums,
// one a cycle, before the first word is accepted; configuration is taken meanwhile.
module log_band_spectrum_waterfall
	import lbsw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_ACC   = 10'b0000000100,
		ST_BRD   = 10'b0000001000,
		ST_AVG   = 10'b0000010000,
		ST_CLAMP = 10'b0000100000,
		ST_DIV   = 10'b0001000000,
		ST_EMIT  = 10'b0010000000,
		ST_RREAD = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// Two memories: band sums and the history store.
	logic [SumW-1:0] sum_mem [Bands];
	logic [7:0]      hist_mem [HistEntries];
	logic [SumW-1:0] sum_rd_q;
	logic [7:0]      hist_rd_q;

	logic [15:0]     ceiling_q, floor_q;
	logic [CntW-1:0] bin_cnt_q;
	logic [15:0]     run_peak_q, scale_peak_q;
	logic [ColW-1:0] newest_q;
	logic [HistAw-1:0] clr_idx_q;
	logic [BandW-1:0] band_q;
	logic [BandW-1:0] acc_band_q;
	logic            bin_hit_q;
	logic [15:0]     mag_q;
	logic            fend_q;
	logic [15:0]     avg_q;
	logic [23:0]     num_q;   // 255*avg, shifted left as quotient bits enter
	logic [16:0]     rem_q;
	logic [4:0]      div_cnt_q;
	logic [23:0]     quo_q;
	out_word_t       out_q;
	logic            out_valid_q;

	// Configuration port.
	assign pready = 1'b1;
	always_comb begin
		case (paddr)
			RegCeiling: prdata = {16'd0, ceiling_q};
			RegFloor:   prdata = {16'd0, floor_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= 16'hFFFF;
			floor_q <= 16'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr == RegCeiling) ceiling_q <= pwdata[15:0];
			if (paddr == RegFloor) floor_q <= pwdata[15:0];
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	wire in_fire = in_valid && in_ready;

	// A column word is loaded only once the output register is free or being emptied.
	wire emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Band covering the current bin: bands overlap nowhere, so take the single match.
	logic            bin_hit;
	logic [BandW-1:0] bin_band;
	always_comb begin
		bin_hit = 1'b0;
		bin_band = '0;
		for (int b = 0; b < Bands; b++) begin
			if (bin_cnt_q >= band_lo(BandW'(b)) && bin_cnt_q < band_hi(BandW'(b))) begin
				bin_hit = 1'b1;
				bin_band = BandW'(b);
			end
		end
	end

	// Average by reciprocal multiply, registered before the clamp.
	logic [CntW-1:0] band_cnt;
	logic [49:0]     avg_prod;
	assign band_cnt = band_hi(band_q) - band_lo(band_q);
	assign avg_prod = sum_rd_q * band_recip(band_cnt);

	logic [15:0] avg_clamped;
	always_comb begin
		avg_clamped = avg_q;
		if (avg_q > ceiling_q) avg_clamped = 16'd0;
		if (avg_clamped < floor_q) avg_clamped = floor_q;
	end

	logic [16:0] rem_try;
	assign rem_try = {rem_q[15:0], num_q[23]};

	wire [ColW-1:0] new_col = newest_q - ColW'(1);
	wire [ColW-1:0] rd_col = newest_q + in_word.read_age;

	// Memory ports.
	logic            sum_we;
	logic [BandW-1:0] sum_wa;
	logic [SumW-1:0] sum_wd;
	logic            hist_we;
	logic [HistAw-1:0] hist_wa;
	logic [7:0]      hist_wd;
	logic [BandW-1:0] sum_ra;
	logic [HistAw-1:0] hist_ra;

	always_comb begin
		sum_we = 1'b0;
		sum_wa = acc_band_q;
		sum_wd = sum_rd_q + SumW'(mag_q);
		hist_we = 1'b0;
		hist_wa = {band_q, new_col};
		hist_wd = (quo_q > 24'd255) ? 8'd255 : quo_q[7:0];
		sum_ra = (state_q == ST_IDLE) ? bin_band : band_q;
		hist_ra = {in_word.read_band, rd_col};
		case (state_q)
			ST_CLEAR: begin
				hist_we = 1'b1;
				hist_wa = clr_idx_q;
				hist_wd = 8'd0;
				sum_we = 1'b1;
				sum_wa = clr_idx_q[BandW-1:0];
				sum_wd = '0;
			end
			ST_ACC: sum_we = bin_hit_q;
			ST_EMIT: begin
				hist_we = 1'b1;
				if (scale_peak_q == 16'd0) hist_wd = 8'd0;
				sum_we = 1'b1;
				sum_wa = band_q;
				sum_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_wa] <= sum_wd;
		sum_rd_q <= sum_mem[sum_ra];
		if (hist_we) hist_mem[hist_wa] <= hist_wd;
		hist_rd_q <= hist_mem[hist_ra];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q <= in_word.bin_magnitude;
			fend_q <= in_word.frame_end;
			acc_band_q <= bin_band;
			bin_hit_q <= bin_hit && !in_word.func;
			out_q.band_row <= in_word.read_band;
			out_q.level_byte <= 8'd0;
			out_q.is_read_reply <= 1'b1;
			out_q.column_last <= 1'b1;
		end
		if (state_q == ST_RREAD) out_q.level_byte <= hist_rd_q;
		if (state_q == ST_AVG) avg_q <= avg_prod[41:26];
		if (state_q == ST_CLAMP) begin
			num_q <= {avg_clamped, 8'd0} - {8'd0, avg_clamped};
			rem_q <= '0;
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			num_q <= {num_q[22:0], 1'b0};
			if (rem_try >= {1'b0, scale_peak_q}) begin
				rem_q <= rem_try - {1'b0, scale_peak_q};
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= rem_try;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
		if (emit_go) begin
			out_q.level_byte <= hist_wd;
			out_q.band_row <= band_q;
			out_q.is_read_reply <= 1'b0;
			out_q.column_last <= (band_q == BandW'(Bands - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			bin_cnt_q <= '0;
			run_peak_q <= '0;
			scale_peak_q <= '0;
			newest_q <= '0;
			band_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go || state_q == ST_OUT) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + HistAw'(1);
					if (clr_idx_q == HistAw'(HistEntries - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= in_word.func ? ST_RREAD : ST_ACC;
					end
				end
				ST_ACC: begin
					if (bin_cnt_q < CntW'(FftBins - 1)) bin_cnt_q <= bin_cnt_q + 7'd1;
					else bin_cnt_q <= 7'd127;
					if (fend_q) begin
						band_q <= '0;
						state_q <= ST_BRD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BRD: state_q <= ST_AVG;
				ST_AVG: state_q <= ST_CLAMP;
				ST_CLAMP: begin
					if (avg_clamped > run_peak_q) run_peak_q <= avg_clamped;
					div_cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd23) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (band_q == BandW'(Bands - 1)) begin
							newest_q <= new_col;
							bin_cnt_q <= '0;
							if (run_peak_q != 16'd0) scale_peak_q <= run_peak_q;
							state_q <= ST_IDLE;
						end else begin
							band_q <= band_q + BandW'(1);
							state_q <= ST_BRD;
						end
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_RREAD: state_q <= ST_OUT;
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q) else $error("output during clear");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE)) else $error("ready outside idle");
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_q)) else $error("result changed");
`endif

endmodule
